@@ rtl/core/dmadl_pkg.sv @@
// Shared types and constants for the DMA descriptor list builder.
`timescale 1ns / 1ps

package dmadl_pkg;

    // Field widths
    localparam int ADDR_W      = 32;
    localparam int SEG_BYTES_W = 21;
    localparam int RUN_LEN_W   = 22;
    localparam int REQ_W       = 16;
    localparam int CMD_W       = 3;

    // Largest byte count of one descriptor
    localparam logic [RUN_LEN_W-1:0] CHUNK_BYTES = RUN_LEN_W'(16'hfe00);

    // Results given for one segment at most
    localparam int RESULT_CAP = 20;
    localparam int RES_CNT_W  = 5;

    // Descriptor command codes
    localparam logic [CMD_W-1:0] CMD_OUTPUT_MORE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OUTPUT_LAST = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INPUT_MORE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INPUT_LAST  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP        = 3'd4;

    // One result item
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [REQ_W-1:0]  byte_count;
        logic [ADDR_W-1:0] phys_addr;
        logic              status;
        logic              end_of_run;
    } res_t;

    // Operation request to the shared adder
    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              sub;
    } alu_req_t;

endpackage

@@ rtl/core/dmadl_alu.sv @@
// Shared 32-bit add/subtract unit used by the descriptor sequencer.
`timescale 1ns / 1ps

module dmadl_alu (
    input  dmadl_pkg::alu_req_t           req,
    output logic [dmadl_pkg::ADDR_W-1:0]  sum
);

    // Add or subtract modulo 2^32
    assign sum = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

@@ rtl/core/dmadl_seq.sv @@
// Sequencer and run state of the descriptor list builder.
`timescale 1ns / 1ps

module dmadl_seq #(
    parameter int MAX_DESCRIPTORS   = 256,
    parameter int MAX_SEGMENT_BYTES = 1048576
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dmadl_pkg::ADDR_W-1:0]         seg_addr,
    input  logic [dmadl_pkg::SEG_BYTES_W-1:0]    seg_bytes,
    input  logic                                 write_dir,
    input  logic                                 last_segment,
    input  logic                                 out_free,
    output logic                                 push,
    output dmadl_pkg::res_t                      res,
    output dmadl_pkg::alu_req_t                  alu_req,
    input  logic [dmadl_pkg::ADDR_W-1:0]         alu_sum
);

    localparam int DCNT_W = $clog2(MAX_DESCRIPTORS);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(MAX_DESCRIPTORS - 1);
    localparam int MAXB_W = $clog2(MAX_SEGMENT_BYTES + 1);
    localparam int CMP_W  = (MAXB_W > dmadl_pkg::SEG_BYTES_W) ? MAXB_W
                                                              : dmadl_pkg::SEG_BYTES_W;
    localparam logic [dmadl_pkg::ADDR_W-1:0] CHUNK_W32 =
        dmadl_pkg::ADDR_W'(dmadl_pkg::CHUNK_BYTES);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_MATCH     = 3'd1;
    localparam logic [2:0] S_MERGE     = 3'd2;
    localparam logic [2:0] S_SPLIT     = 3'd3;
    localparam logic [2:0] S_DRAIN     = 3'd4;
    localparam logic [2:0] S_DRAIN_LEN = 3'd5;
    localparam logic [2:0] S_LAST      = 3'd6;
    localparam logic [2:0] S_STOP      = 3'd7;

    logic [2:0]                            state_reg, state_next;
    logic [dmadl_pkg::ADDR_W-1:0]          seg_addr_reg, seg_addr_next;
    logic [dmadl_pkg::SEG_BYTES_W-1:0]     seg_bytes_reg, seg_bytes_next;
    logic                                  last_reg, last_next;
    logic [dmadl_pkg::ADDR_W-1:0]          run_start_reg, run_start_next;
    logic [dmadl_pkg::RUN_LEN_W-1:0]       run_length_reg, run_length_next;
    logic                                  run_open_reg, run_open_next;
    logic [DCNT_W-1:0]                     desc_count_reg, desc_count_next;
    logic                                  overflowed_reg, overflowed_next;
    logic                                  in_transfer_reg, in_transfer_next;
    logic                                  direction_reg, direction_next;
    logic [dmadl_pkg::RES_CNT_W-1:0]       res_cnt_reg, res_cnt_next;

    logic                                  data_req;
    logic [dmadl_pkg::RUN_LEN_W-1:0]       data_cnt;
    logic [dmadl_pkg::ADDR_W-1:0]          data_addr;
    logic                                  data_last;
    logic                                  res_req;
    logic [dmadl_pkg::SEG_BYTES_W-1:0]     seg_sat;

    assign in_ready = (state_reg == S_IDLE);

    // Saturate the segment length
    assign seg_sat = (CMP_W'(seg_bytes) > CMP_W'(MAX_SEGMENT_BYTES))
                   ? dmadl_pkg::SEG_BYTES_W'(MAX_SEGMENT_BYTES) : seg_bytes;

    always_comb begin
        state_next       = state_reg;
        seg_addr_next    = seg_addr_reg;
        seg_bytes_next   = seg_bytes_reg;
        last_next        = last_reg;
        run_start_next   = run_start_reg;
        run_length_next  = run_length_reg;
        run_open_next    = run_open_reg;
        desc_count_next  = desc_count_reg;
        overflowed_next  = overflowed_reg;
        in_transfer_next = in_transfer_reg;
        direction_next   = direction_reg;
        res_cnt_next     = res_cnt_reg;
        data_req         = 1'b0;
        data_cnt         = run_length_reg;
        data_addr        = run_start_reg;
        data_last        = 1'b0;
        res_req          = 1'b0;
        res              = '0;
        push             = 1'b0;
        alu_req          = '{a: run_start_reg,
                             b: dmadl_pkg::ADDR_W'(run_length_reg),
                             sub: 1'b0};

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    seg_addr_next  = seg_addr;
                    seg_bytes_next = seg_sat;
                    last_next      = last_segment;
                    res_cnt_next   = '0;
                    if (!in_transfer_reg) begin
                        in_transfer_next = 1'b1;
                        direction_next   = write_dir;
                        desc_count_next  = '0;
                        overflowed_next  = 1'b0;
                        run_open_next    = 1'b0;
                        run_start_next   = '0;
                        run_length_next  = '0;
                    end
                    state_next = S_MATCH;
                end
            end
            // Compare run end against the new segment address
            S_MATCH: begin
                if (seg_bytes_reg == '0) begin
                    state_next = S_LAST;
                end else if (run_open_reg && (alu_sum == seg_addr_reg)) begin
                    state_next = S_MERGE;
                end else begin
                    state_next = S_SPLIT;
                end
            end
            // Extend the open run
            S_MERGE: begin
                alu_req = '{a: dmadl_pkg::ADDR_W'(run_length_reg),
                            b: dmadl_pkg::ADDR_W'(seg_bytes_reg),
                            sub: 1'b0};
                run_length_next = alu_sum[dmadl_pkg::RUN_LEN_W-1:0];
                state_next      = S_DRAIN;
            end
            // Flush the held run and open a new one
            S_SPLIT: begin
                if (out_free) begin
                    data_req        = run_open_reg;
                    run_start_next  = seg_addr_reg;
                    run_length_next = dmadl_pkg::RUN_LEN_W'(seg_bytes_reg);
                    run_open_next   = 1'b1;
                    state_next      = S_DRAIN;
                end
            end
            // Emit one full chunk and advance the run start, or go on to S_LAST when none remains
            S_DRAIN: begin
                if (run_length_reg > dmadl_pkg::CHUNK_BYTES) begin
                    if (out_free) begin
                        data_req       = 1'b1;
                        data_cnt       = dmadl_pkg::CHUNK_BYTES;
                        alu_req        = '{a: run_start_reg, b: CHUNK_W32, sub: 1'b0};
                        run_start_next = alu_sum;
                        state_next     = S_DRAIN_LEN;
                    end
                end else begin
                    state_next = S_LAST;
                end
            end
            // Shrink the run length by one chunk
            S_DRAIN_LEN: begin
                alu_req = '{a: dmadl_pkg::ADDR_W'(run_length_reg),
                            b: CHUNK_W32,
                            sub: 1'b1};
                run_length_next = alu_sum[dmadl_pkg::RUN_LEN_W-1:0];
                state_next      = S_DRAIN;
            end
            // Emit the held run as the final descriptor on the last segment, else return to idle
            S_LAST: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    data_req   = run_open_reg;
                    data_last  = 1'b1;
                    state_next = S_STOP;
                end
            end
            // Close the transfer with a stop or error result
            S_STOP: begin
                if (out_free) begin
                    res_req          = 1'b1;
                    res.command      = dmadl_pkg::CMD_STOP;
                    res.status       = overflowed_reg;
                    res.end_of_run   = 1'b1;
                    in_transfer_next = 1'b0;
                    run_open_next    = 1'b0;
                    run_start_next   = '0;
                    run_length_next  = '0;
                    desc_count_next  = '0;
                    overflowed_next  = 1'b0;
                    state_next       = S_IDLE;
                end
            end
        endcase

        // Count the descriptor or raise overflow
        if (data_req && !overflowed_reg) begin
            if (desc_count_reg == DCNT_LAST) begin
                overflowed_next = 1'b1;
            end else begin
                desc_count_next = desc_count_reg + 1'b1;
                res_req         = 1'b1;
                res.byte_count  = data_cnt[dmadl_pkg::REQ_W-1:0];
                res.phys_addr   = data_addr;
                if (direction_reg) begin
                    res.command = data_last ? dmadl_pkg::CMD_OUTPUT_LAST
                                            : dmadl_pkg::CMD_OUTPUT_MORE;
                end else begin
                    res.command = data_last ? dmadl_pkg::CMD_INPUT_LAST
                                            : dmadl_pkg::CMD_INPUT_MORE;
                end
            end
        end

        // Drop results beyond the per-segment cap
        if (res_req && (res_cnt_reg != dmadl_pkg::RES_CNT_W'(dmadl_pkg::RESULT_CAP))) begin
            push         = 1'b1;
            res_cnt_next = res_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            run_start_reg   <= '0;
            run_length_reg  <= '0;
            run_open_reg    <= 1'b0;
            desc_count_reg  <= '0;
            overflowed_reg  <= 1'b0;
            in_transfer_reg <= 1'b0;
            direction_reg   <= 1'b0;
            res_cnt_reg     <= '0;
        end else begin
            state_reg       <= state_next;
            run_start_reg   <= run_start_next;
            run_length_reg  <= run_length_next;
            run_open_reg    <= run_open_next;
            desc_count_reg  <= desc_count_next;
            overflowed_reg  <= overflowed_next;
            in_transfer_reg <= in_transfer_next;
            direction_reg   <= direction_next;
            res_cnt_reg     <= res_cnt_next;
        end
    end

    // Segment payload holds no reset
    always_ff @(posedge aclk) begin
        seg_addr_reg  <= seg_addr_next;
        seg_bytes_reg <= seg_bytes_next;
        last_reg      <= last_next;
    end

    a_overflow_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        overflowed_reg |-> (desc_count_reg == DCNT_LAST))
        else $error("overflow set below the descriptor limit");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("result pushed into a full output register");

    a_closed_run_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_open_reg |-> (run_length_reg == '0))
        else $error("closed run holds bytes");

    a_idle_run_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_IDLE) && run_open_reg) |->
            (run_length_reg <= dmadl_pkg::CHUNK_BYTES))
        else $error("held run exceeds one chunk between segments");

endmodule

@@ rtl/core/dma_descriptor_list_builder.sv @@
// Top level of the DMA descriptor list builder: sequencer, adder and output register.
// Each accepted segment holds the input through the accepting idle state, the compare
// of the run end, the merge or split of the run, the check that finds no full chunk
// left and the finish; every full 65024-byte chunk cut from the run adds an emit step
// and a length step, and the last segment adds the stop result. A zero-length segment
// skips the merge and the chunk check. The pace is set by the single shared 32-bit
// adder, which forms the run end, the run start and the run length in turn, and by the
// one-entry output register: the split, chunk, final and stop states wait while a result
// is still untaken. s_ready is high only between segments.
`timescale 1ns / 1ps

module dma_descriptor_list_builder #(
    parameter int MAX_DESCRIPTORS   = 256,
    parameter int MAX_SEGMENT_BYTES = 1048576
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dmadl_pkg::ADDR_W-1:0]        s_seg_addr,
    input  logic [dmadl_pkg::SEG_BYTES_W-1:0]   s_seg_bytes,
    input  logic                                s_write_dir,
    input  logic                                s_last_segment,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dmadl_pkg::CMD_W-1:0]         m_command,
    output logic [dmadl_pkg::REQ_W-1:0]         m_byte_count,
    output logic [dmadl_pkg::ADDR_W-1:0]        m_phys_addr,
    output logic                                m_status,
    output logic                                m_end_of_run
);

    logic                          out_free;
    logic                          push;
    dmadl_pkg::res_t               res;
    dmadl_pkg::alu_req_t           alu_req;
    logic [dmadl_pkg::ADDR_W-1:0]  alu_sum;
    logic                          m_valid_reg, m_valid_next;
    dmadl_pkg::res_t               res_reg, res_next;

    dmadl_seq #(
        .MAX_DESCRIPTORS   (MAX_DESCRIPTORS),
        .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .seg_addr     (s_seg_addr),
        .seg_bytes    (s_seg_bytes),
        .write_dir    (s_write_dir),
        .last_segment (s_last_segment),
        .out_free     (out_free),
        .push         (push),
        .res          (res),
        .alu_req      (alu_req),
        .alu_sum      (alu_sum)
    );

    dmadl_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    // Output register: free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (push) begin
            m_valid_next = 1'b1;
            res_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_command    = res_reg.command;
    assign m_byte_count = res_reg.byte_count;
    assign m_phys_addr  = res_reg.phys_addr;
    assign m_status     = res_reg.status;
    assign m_end_of_run = res_reg.end_of_run;

endmodule

@@ verif/tb_dma_descriptor_list_builder.sv @@
// Self-checking testbench for the DMA descriptor list builder.
`timescale 1ns / 1ps

module tb_dma_descriptor_list_builder;

    localparam int MAX_DESC      = 256;
    localparam int MAX_SEG_BYTES = 1048576;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;

    // Clock, reset and block ports; the driven inputs are known from time zero
    logic                              aclk           = 1'b0;
    logic                              aresetn        = 1'b0;
    logic                              s_valid        = 1'b0;
    logic                              s_ready;
    logic [dmadl_pkg::ADDR_W-1:0]      s_seg_addr     = '0;
    logic [dmadl_pkg::SEG_BYTES_W-1:0] s_seg_bytes    = '0;
    logic                              s_write_dir    = 1'b0;
    logic                              s_last_segment = 1'b0;
    logic                              m_valid;
    logic                              m_ready        = 1'b0;
    logic [dmadl_pkg::CMD_W-1:0]       m_command;
    logic [dmadl_pkg::REQ_W-1:0]       m_byte_count;
    logic [dmadl_pkg::ADDR_W-1:0]      m_phys_addr;
    logic                              m_status;
    logic                              m_end_of_run;

    // Shared run control
    bit idle_on   = 1'b0;
    int hold_req  = 0;
    int cycle_cnt = 0;

    // Descriptor predictor state
    logic [dmadl_pkg::ADDR_W-1:0]    run_base;
    logic [dmadl_pkg::RUN_LEN_W-1:0] run_len;
    bit                              run_live;
    int unsigned                     desc_total;
    bit                              table_full;
    bit                              xfer_open;
    bit                              dir_out;
    int                              step_results;
    dmadl_pkg::res_t                 expected_desc[$];

    // Run statistics
    int segs_sent     = 0;
    int xfers_done    = 0;
    int overflow_runs = 0;
    int results_seen  = 0;
    int mismatches    = 0;

    dma_descriptor_list_builder #(
        .MAX_DESCRIPTORS   (MAX_DESC),
        .MAX_SEGMENT_BYTES (MAX_SEG_BYTES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_seg_addr     (s_seg_addr),
        .s_seg_bytes    (s_seg_bytes),
        .s_write_dir    (s_write_dir),
        .s_last_segment (s_last_segment),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_command      (m_command),
        .m_byte_count   (m_byte_count),
        .m_phys_addr    (m_phys_addr),
        .m_status       (m_status),
        .m_end_of_run   (m_end_of_run)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Queue one expected descriptor, dropping any beyond the per-segment cap
    function automatic void queue_result(input dmadl_pkg::res_t r);
        if (step_results >= dmadl_pkg::RESULT_CAP) begin
            return;
        end
        step_results++;
        expected_desc.push_back(r);
    endfunction

    // Count a data descriptor against the table, or flag the overflow
    function automatic void queue_data(input logic [dmadl_pkg::RUN_LEN_W-1:0] nbytes,
                                       input logic [dmadl_pkg::ADDR_W-1:0] addr,
                                       input bit closing);
        dmadl_pkg::res_t r;
        if (table_full) begin
            return;
        end
        if (desc_total + 1 >= MAX_DESC) begin
            table_full = 1'b1;
            return;
        end
        desc_total++;
        if (dir_out) begin
            r.command = closing ? dmadl_pkg::CMD_OUTPUT_LAST : dmadl_pkg::CMD_OUTPUT_MORE;
        end else begin
            r.command = closing ? dmadl_pkg::CMD_INPUT_LAST : dmadl_pkg::CMD_INPUT_MORE;
        end
        r.byte_count = nbytes[dmadl_pkg::REQ_W-1:0];
        r.phys_addr  = addr;
        r.status     = 1'b0;
        r.end_of_run = 1'b0;
        queue_result(r);
    endfunction

    // Merge or split the run for one segment and work out its descriptors
    function automatic void predict_descriptors(input logic [dmadl_pkg::ADDR_W-1:0] addr,
                                                input logic [dmadl_pkg::SEG_BYTES_W-1:0] nbytes,
                                                input logic wdir, input logic closing);
        logic [dmadl_pkg::RUN_LEN_W-1:0] seg_len;
        logic [dmadl_pkg::ADDR_W-1:0]    run_end;
        dmadl_pkg::res_t                 stop_r;
        step_results = 0;
        seg_len = (nbytes > MAX_SEG_BYTES) ? dmadl_pkg::RUN_LEN_W'(MAX_SEG_BYTES)
                                           : dmadl_pkg::RUN_LEN_W'(nbytes);
        if (!xfer_open) begin
            xfer_open  = 1'b1;
            dir_out    = wdir;
            desc_total = 0;
            table_full = 1'b0;
            run_live   = 1'b0;
            run_base   = '0;
            run_len    = '0;
        end
        if (seg_len != 0) begin
            run_end = run_base + dmadl_pkg::ADDR_W'(run_len);
            if (run_live && run_end == addr) begin
                run_len = run_len + seg_len;
            end else begin
                if (run_live) begin
                    queue_data(run_len, run_base, 1'b0);
                end
                run_base = addr;
                run_len  = seg_len;
                run_live = 1'b1;
            end
            // Cut full chunks while more bytes follow them
            while (run_len > dmadl_pkg::CHUNK_BYTES) begin
                queue_data(dmadl_pkg::CHUNK_BYTES, run_base, 1'b0);
                run_base = run_base + dmadl_pkg::ADDR_W'(dmadl_pkg::CHUNK_BYTES);
                run_len  = run_len - dmadl_pkg::CHUNK_BYTES;
            end
        end
        if (closing) begin
            if (run_live) begin
                queue_data(run_len, run_base, 1'b1);
            end
            stop_r.command    = dmadl_pkg::CMD_STOP;
            stop_r.byte_count = '0;
            stop_r.phys_addr  = '0;
            stop_r.status     = table_full;
            stop_r.end_of_run = 1'b1;
            queue_result(stop_r);
            if (table_full) begin
                overflow_runs++;
            end
            xfers_done++;
            xfer_open  = 1'b0;
            run_live   = 1'b0;
            run_base   = '0;
            run_len    = '0;
            desc_total = 0;
            table_full = 1'b0;
        end
    endfunction

    function automatic void report_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    // Offer one segment and hold it until the block accepts it
    task automatic send_segment(input logic [dmadl_pkg::ADDR_W-1:0] addr,
                                input logic [dmadl_pkg::SEG_BYTES_W-1:0] nbytes,
                                input logic wdir, input logic closing);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_seg_addr     <= addr;
        s_seg_bytes    <= nbytes;
        s_write_dir    <= wdir;
        s_last_segment <= closing;
        do @(posedge aclk); while (!s_ready);
        predict_descriptors(addr, nbytes, wdir, closing);
        segs_sent++;
    endtask

    // A lone zero-length last segment gives only the stop descriptor
    task automatic test_empty_transfer();
        send_segment(32'h0000_0000, '0, 1'b1, 1'b1);
    endtask

    // Output direction, merge across the address wrap, zero-length segment mid-transfer
    task automatic test_write_wrap();
        send_segment(32'hFFFF_FF00, 21'h000100, 1'b1, 1'b0);
        send_segment(32'h0000_0000, 21'd65024, 1'b0, 1'b0);
        send_segment(32'hFFFF_FFFF, '0, 1'b1, 1'b0);
        send_segment(32'h8000_0000, 21'd1, 1'b1, 1'b1);
    endtask

    // Input direction: exactly one chunk held, one byte over, a full 1 MiB segment
    task automatic test_read_chunks();
        send_segment(32'h0000_1000, 21'd65024, 1'b0, 1'b0);
        send_segment(32'h0000_1000 + 32'd65024, 21'd1, 1'b1, 1'b0);
        send_segment(32'hFFFF_FFFF, 21'd1048576, 1'b0, 1'b1);
    endtask

    // Sixteen saturated segments exceed the table and end with the error result
    task automatic test_table_overflow();
        for (int i = 0; i < 16; i++) begin
            send_segment($urandom, 21'h1FFFFF, 1'b0, i == 15);
        end
    endtask

    // Hold the receiver for a long stretch while large segments keep arriving
    task automatic test_receiver_hold();
        logic [dmadl_pkg::ADDR_W-1:0] base;
        base     = $urandom;
        hold_req = HOLD_CYCLES;
        send_segment(base, 21'd1048576, 1'b1, 1'b0);
        send_segment(base + 32'd1048576, 21'd1048576, 1'b1, 1'b0);
        send_segment($urandom, 21'd512, 1'b1, 1'b1);
    endtask

    // Random transfers, mostly small page-like segments with frequent contiguity
    task automatic test_random_transfers(input int n_items, input bit allow_idle);
        int                                sent;
        int                                nsegs;
        logic [dmadl_pkg::ADDR_W-1:0]      addr;
        logic [dmadl_pkg::ADDR_W-1:0]      tail_addr;
        logic [dmadl_pkg::SEG_BYTES_W-1:0] nbytes;
        logic [dmadl_pkg::SEG_BYTES_W-1:0] eff;
        sent = 0;
        while (sent < n_items) begin
            idle_on   = allow_idle && ($urandom_range(0, 3) != 0);
            nsegs     = $urandom_range(1, 8);
            tail_addr = $urandom;
            for (int i = 0; i < nsegs; i++) begin
                case ($urandom_range(0, 9))
                    0:       nbytes = '0;
                    1:       nbytes = dmadl_pkg::SEG_BYTES_W'($urandom_range(0, 21'h1FFFFF));
                    2:       nbytes = dmadl_pkg::SEG_BYTES_W'($urandom_range(65000, 200000));
                    3:       nbytes = 21'd4096;
                    default: nbytes = dmadl_pkg::SEG_BYTES_W'($urandom_range(1, 8192));
                endcase
                case ($urandom_range(0, 5))
                    0:       addr = $urandom;
                    1:       addr = 32'hFFFF_FFFF - $urandom_range(0, 8192);
                    2:       addr = tail_addr + $urandom_range(1, 64);
                    default: addr = tail_addr;
                endcase
                send_segment(addr, nbytes, 1'($urandom_range(0, 1)), i == nsegs - 1);
                eff = (nbytes > MAX_SEG_BYTES) ? dmadl_pkg::SEG_BYTES_W'(MAX_SEG_BYTES)
                                               : nbytes;
                if (eff != 0) begin
                    tail_addr = addr + dmadl_pkg::ADDR_W'(eff);
                end
                sent++;
            end
        end
        idle_on = 1'b0;
    endtask

    // Receiver: long hold on request, random stall bursts, otherwise ready
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_req != 0) begin
                m_ready <= 1'b0;
                repeat (hold_req) @(posedge aclk);
                hold_req = 0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compare each descriptor transfer with the oldest expectation
    always @(posedge aclk) begin
        dmadl_pkg::res_t seen;
        dmadl_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            seen.command    = m_command;
            seen.byte_count = m_byte_count;
            seen.phys_addr  = m_phys_addr;
            seen.status     = m_status;
            seen.end_of_run = m_end_of_run;
            results_seen++;
            if (expected_desc.size() == 0) begin
                report_error($sformatf("unexpected result cmd=%0d cnt=%0d addr=%h st=%b eor=%b",
                    seen.command, seen.byte_count, seen.phys_addr, seen.status,
                    seen.end_of_run));
            end else begin
                want = expected_desc.pop_front();
                if (seen.command !== want.command || seen.byte_count !== want.byte_count ||
                    seen.phys_addr !== want.phys_addr || seen.status !== want.status ||
                    seen.end_of_run !== want.end_of_run) begin
                    report_error($sformatf({"result %0d: exp cmd=%0d cnt=%0d addr=%h st=%b ",
                        "eor=%b, got cmd=%0d cnt=%0d addr=%h st=%b eor=%b"}, results_seen,
                        want.command, want.byte_count, want.phys_addr, want.status,
                        want.end_of_run, seen.command, seen.byte_count, seen.phys_addr,
                        seen.status, seen.end_of_run));
                end
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_cnt, expected_desc.size());
        $display("Verification failed");
        $finish;
    end

    initial begin
        xfer_open  = 1'b0;
        run_live   = 1'b0;
        run_base   = '0;
        run_len    = '0;
        desc_total = 0;
        table_full = 1'b0;
        dir_out    = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;

        test_empty_transfer();
        test_write_wrap();
        test_read_chunks();
        test_table_overflow();
        test_receiver_hold();
        test_random_transfers(200, 1'b1);
        test_random_transfers(55, 1'b0);

        // Drain the outstanding descriptors, then let the block settle
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_desc.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d segments in %0d transfers (%0d with table overflow)",
                 segs_sent, xfers_done, overflow_runs);
        $display("Checked %0d descriptors, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
